FILE: src/pfra_pkg.sv
package pfra_pkg;

  // Register indexes on the configuration channel.
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_BYTE     = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEVICE_ADDRESS  = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_RETURN_FRAME_ID = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_CODE      = 8'd3;

  // Register values after reset.
  localparam logic [7:0] RST_HEADER_BYTE     = 8'd170;
  localparam logic [7:0] RST_DEVICE_ADDRESS  = 8'd255;
  localparam logic [7:0] RST_RETURN_FRAME_ID = 8'd224;
  localparam logic [7:0] RST_WRITE_CODE      = 8'd225;

  // Fixed frame positions, and the frame bytes that the length byte does not count.
  localparam int unsigned LenPos     = 3;
  localparam int unsigned IdLoPos    = 4;
  localparam int unsigned IdHiPos    = 5;
  localparam int unsigned Val0Pos    = 6;
  localparam int unsigned Val1Pos    = 7;
  localparam int unsigned Val2Pos    = 8;
  localparam int unsigned Val3Pos    = 9;
  localparam int unsigned LenOverhead = 6;

  // Acknowledge frame byte positions.
  localparam int unsigned AckIdxW = 4;
  localparam logic [AckIdxW-1:0] ACK_POS_HEADER  = 4'd0;
  localparam logic [AckIdxW-1:0] ACK_POS_ADDRESS = 4'd1;
  localparam logic [AckIdxW-1:0] ACK_POS_FUNC_ID = 4'd2;
  localparam logic [AckIdxW-1:0] ACK_POS_LENGTH  = 4'd3;
  localparam logic [AckIdxW-1:0] ACK_POS_CODE    = 4'd4;
  localparam logic [AckIdxW-1:0] ACK_POS_RX_SUM  = 4'd5;
  localparam logic [AckIdxW-1:0] ACK_POS_RX_ADD  = 4'd6;
  localparam logic [AckIdxW-1:0] ACK_POS_OWN_SUM = 4'd7;
  localparam logic [AckIdxW-1:0] ACK_POS_OWN_ADD = 4'd8;

  // Payload length carried in the acknowledge frame.
  localparam logic [7:0] ACK_LENGTH = 8'd3;

  // Result kinds.
  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_PARAM = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;
    logic walk_clear;
    logic walk_step;
    logic ack_clear;
    logic ack_step;
    logic param_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full_now;
    logic len_ok;
    logic walk_last;
    logic sums_match;
    logic ack_last;
  } sts_t;

endpackage

FILE: src/pfra_if.sv
// Received byte channel.
interface pfra_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Result channel: acknowledge bytes and parameter updates.
interface pfra_res_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [7:0]         tx_byte;
  logic [15:0]        param_id;
  logic signed [31:0] param_value;
  logic               last;

  modport source (output valid, output result_kind, output tx_byte, output param_id,
                  output param_value, output last, input ready);
  modport sink (input valid, input result_kind, input tx_byte, input param_id,
                input param_value, input last, output ready);
endinterface

// Configuration write channel.
interface pfra_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/pfra_ctrl.sv
module pfra_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rx_valid_i,
  output logic             rx_ready_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  input  pfra_pkg::sts_t   sts_i,
  output pfra_pkg::cmd_t   cmd_o
);

  localparam logic [2:0] ST_HUNT    = 3'd0;
  localparam logic [2:0] ST_CHECK   = 3'd1;
  localparam logic [2:0] ST_WALK    = 3'd2;
  localparam logic [2:0] ST_COMPARE = 3'd3;
  localparam logic [2:0] ST_ACK     = 3'd4;
  localparam logic [2:0] ST_PARAM   = 3'd5;

  logic [2:0] state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    rx_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_HUNT: begin
        rx_ready_o = 1'b1;
        if (rx_valid_i) begin
          cmd_o.store = 1'b1;
          if (sts_i.full_now) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        cmd_o.walk_clear = 1'b1;
        state_d = sts_i.len_ok ? ST_WALK : ST_HUNT;
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_last) begin
          state_d = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        if (sts_i.sums_match) begin
          cmd_o.ack_clear = 1'b1;
          state_d = ST_ACK;
        end else begin
          state_d = ST_HUNT;
        end
      end
      ST_ACK: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          cmd_o.ack_step = 1'b1;
          if (sts_i.ack_last) begin
            state_d = ST_PARAM;
          end
        end
      end
      ST_PARAM: begin
        res_valid_o     = 1'b1;
        cmd_o.param_sel = 1'b1;
        if (res_ready_i) begin
          state_d = ST_HUNT;
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/pfra_dp.sv
module pfra_dp #(
  parameter int unsigned FrameBytes = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pfra_pkg::cmd_t                cmd_i,
  output pfra_pkg::sts_t                sts_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          cfg_we_i,
  input  logic [pfra_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [7:0]                    cfg_data_i,
  output logic                          result_kind_o,
  output logic [7:0]                    tx_byte_o,
  output logic [15:0]                   param_id_o,
  output logic signed [31:0]            param_value_o,
  output logic                          last_o
);

  // The buffer always covers the parameter bytes; entries past the frame stay unwritten.
  localparam int unsigned BufDepth = (FrameBytes < 10) ? 10 : FrameBytes;
  localparam int unsigned IdxW     = $clog2(BufDepth);
  localparam int unsigned CntW     = $clog2(FrameBytes + 1);
  localparam int unsigned MaxLen   = FrameBytes - pfra_pkg::LenOverhead;

  logic [7:0]                    fbuf_q [BufDepth];
  logic [CntW-1:0]               cnt_q, cnt_d, cnt_inc;
  logic [IdxW-1:0]               wr_idx;
  logic [7:0]                    byte0;
  logic                          hdr_ok;
  logic                          full_now;
  logic [IdxW-1:0]               idx_q;
  logic [7:0]                    s_q, a_q, s_sum, a_sum;
  logic [8:0]                    walk_end;
  logic [pfra_pkg::AckIdxW-1:0]  ack_idx_q;
  logic [7:0]                    s2_q, a2_q, s2_sum, a2_sum;
  logic [7:0]                    ack_byte;
  logic [7:0]                    hdr_q, addr_q, fid_q, code_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q  <= pfra_pkg::RST_HEADER_BYTE;
      addr_q <= pfra_pkg::RST_DEVICE_ADDRESS;
      fid_q  <= pfra_pkg::RST_RETURN_FRAME_ID;
      code_q <= pfra_pkg::RST_WRITE_CODE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pfra_pkg::CFG_HEADER_BYTE:     hdr_q  <= cfg_data_i;
        pfra_pkg::CFG_DEVICE_ADDRESS:  addr_q <= cfg_data_i;
        pfra_pkg::CFG_RETURN_FRAME_ID: fid_q  <= cfg_data_i;
        pfra_pkg::CFG_WRITE_CODE:      code_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Header hunt: the first byte of the buffer must match the header register.
  assign wr_idx   = cnt_q[IdxW-1:0];
  assign cnt_inc  = cnt_q + 1'b1;
  assign byte0    = (cnt_q == '0) ? rx_byte_i : fbuf_q[0];
  assign hdr_ok   = (byte0 == hdr_q);
  assign full_now = hdr_ok && (cnt_inc == CntW'(FrameBytes));

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.store) begin
      cnt_d = (!hdr_ok || full_now) ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Frame buffer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      fbuf_q[wr_idx] <= rx_byte_i;
    end
  end

  // Check walk: one byte of the running sum and the sum of sums per cycle.
  assign s_sum    = s_q + fbuf_q[idx_q];
  assign a_sum    = a_q + s_sum;
  assign walk_end = {1'b0, fbuf_q[pfra_pkg::LenPos]} + 9'd3;

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_clear) begin
      idx_q <= '0;
      s_q   <= '0;
      a_q   <= '0;
    end else if (cmd_i.walk_step) begin
      idx_q <= idx_q + 1'b1;
      s_q   <= s_sum;
      a_q   <= a_sum;
    end
  end

  // Acknowledge byte selection.
  always_comb begin
    unique case (ack_idx_q)
      pfra_pkg::ACK_POS_HEADER:  ack_byte = hdr_q;
      pfra_pkg::ACK_POS_ADDRESS: ack_byte = addr_q;
      pfra_pkg::ACK_POS_FUNC_ID: ack_byte = fid_q;
      pfra_pkg::ACK_POS_LENGTH:  ack_byte = pfra_pkg::ACK_LENGTH;
      pfra_pkg::ACK_POS_CODE:    ack_byte = code_q;
      pfra_pkg::ACK_POS_RX_SUM:  ack_byte = s_q;
      pfra_pkg::ACK_POS_RX_ADD:  ack_byte = a_q;
      pfra_pkg::ACK_POS_OWN_SUM: ack_byte = s2_q;
      pfra_pkg::ACK_POS_OWN_ADD: ack_byte = a2_q;
      default:                   ack_byte = '0;
    endcase
  end

  // The own checks build up as the first seven acknowledge bytes go out.
  assign s2_sum = s2_q + ack_byte;
  assign a2_sum = a2_q + s2_sum;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ack_clear) begin
      ack_idx_q <= '0;
      s2_q      <= '0;
      a2_q      <= '0;
    end else if (cmd_i.ack_step) begin
      ack_idx_q <= ack_idx_q + 1'b1;
      if (ack_idx_q < pfra_pkg::ACK_POS_OWN_SUM) begin
        s2_q <= s2_sum;
        a2_q <= a2_sum;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o.full_now   = full_now;
    sts_o.len_ok     = (fbuf_q[pfra_pkg::LenPos] <= 8'(MaxLen));
    sts_o.walk_last  = (9'(idx_q) == walk_end);
    sts_o.sums_match = (s_q == fbuf_q[FrameBytes-2]) && (a_q == fbuf_q[FrameBytes-1]);
    sts_o.ack_last   = (ack_idx_q == pfra_pkg::ACK_POS_OWN_ADD);
  end

  // Result payload.
  always_comb begin
    if (cmd_i.param_sel) begin
      result_kind_o = pfra_pkg::KIND_PARAM;
      tx_byte_o     = '0;
      param_id_o    = {fbuf_q[pfra_pkg::IdHiPos], fbuf_q[pfra_pkg::IdLoPos]};
      param_value_o = signed'({fbuf_q[pfra_pkg::Val3Pos], fbuf_q[pfra_pkg::Val2Pos],
                               fbuf_q[pfra_pkg::Val1Pos], fbuf_q[pfra_pkg::Val0Pos]});
      last_o        = 1'b1;
    end else begin
      result_kind_o = pfra_pkg::KIND_ACK;
      tx_byte_o     = ack_byte;
      param_id_o    = '0;
      param_value_o = '0;
      last_o        = 1'b0;
    end
  end

endmodule

FILE: src/parameter_frame_receiver_with_ack_core.sv
// Channel   Dir  Payload                                               Transfer when
// rx_i      in   rx_byte[7:0]                                          valid & ready
// res_o     out  result_kind, tx_byte[7:0], param_id[15:0],
//                param_value[31:0] signed, last                        valid & ready
// cfg_i     in   index[7:0], data[7:0]                                 valid & ready
//
// A byte that does not complete a frame is taken and stored or dropped; rx_i stays ready while hunting.
// The byte that completes a frame is followed by the length check and the one-byte-per-cycle
// checksum walk over the first L + 4 buffer bytes, then nine acknowledge bytes and the update.
// While the walk runs or results are pending, rx_i is held not ready; res_o stalls hold all.
// Reset clears the byte count and loads the register defaults; the buffer is not cleared.
// cfg_i is always ready; indexes beyond the register list are ignored.
module parameter_frame_receiver_with_ack_core #(
  parameter int unsigned FrameBytes = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  pfra_rx_if.sink         rx_i,
  pfra_res_if.source      res_o,
  pfra_cfg_if.sink        cfg_i
);

  pfra_pkg::cmd_t cmd;
  pfra_pkg::sts_t sts;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  pfra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_i.valid),
    .rx_ready_o  (rx_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pfra_dp #(
    .FrameBytes (FrameBytes)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rx_byte_i     (rx_i.rx_byte),
    .cfg_we_i      (cfg_i.valid),
    .cfg_idx_i     (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .result_kind_o (res_o.result_kind),
    .tx_byte_o     (res_o.tx_byte),
    .param_id_o    (res_o.param_id),
    .param_value_o (res_o.param_value),
    .last_o        (res_o.last)
  );

endmodule

FILE: src/pfra_checker.sv
module pfra_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               rx_valid_i,
  input logic               rx_ready_i,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input logic               res_kind_i,
  input logic [7:0]         res_tx_i,
  input logic [15:0]        res_id_i,
  input logic signed [31:0] res_value_i,
  input logic               res_last_i
);

  // No byte is taken while results are being offered.
  a_no_rx_during_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rx_ready_i && res_valid_i))
    else $error("rx ready while results are pending");

  // Only the parameter update closes a result burst.
  a_last_is_param: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_last_i == res_kind_i))
    else $error("last flag does not match result kind");

  // Acknowledge results carry zero parameter fields; updates carry a zero byte.
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_kind_i ? (res_tx_i == 8'd0)
                                : (res_id_i == 16'd0 && res_value_i == 32'sd0)))
    else $error("unused result field not zero");

  // After the final transfer of a burst, the block returns to taking bytes.
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && res_last_i |=> !res_valid_i && rx_ready_i)
    else $error("block did not return to receive after last result");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_tx_i) && $stable(res_kind_i))
    else $error("stalled result changed");

endmodule

bind parameter_frame_receiver_with_ack_core pfra_checker u_pfra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rx_valid_i  (rx_i.valid),
  .rx_ready_i  (rx_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_kind_i  (res_o.result_kind),
  .res_tx_i    (res_o.tx_byte),
  .res_id_i    (res_o.param_id),
  .res_value_i (res_o.param_value),
  .res_last_i  (res_o.last)
);

FILE: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FrameBytes    = 12;
  localparam int unsigned AckBytes      = int'(pfra_pkg::ACK_POS_OWN_ADD) + 1;
  localparam int unsigned CfgRegs       = 4;
  localparam int unsigned HalfPeriod    = 4;
  localparam int unsigned ClkPeriod     = 2 * HalfPeriod;
  localparam int unsigned MaxGap        = 18;
  localparam int unsigned TailCycles    = 32;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned PhaseCount    = 5;
  localparam int unsigned PhaseBytes    = 57;
  localparam int unsigned HoldAfter     = 70;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned TimeoutCycles = 200_000;
  localparam int unsigned MaxLen        = FrameBytes - pfra_pkg::LenOverhead;

  // One result as it leaves the block.
  typedef struct {
    logic               kind;
    logic [7:0]         tx;
    logic [15:0]        id;
    logic signed [31:0] val;
    logic               last;
  } result_t;

  // Directed rows either expect nothing at all or take what the predictor gives.
  typedef enum logic {OUT_NONE, OUT_PREDICT} outcome_e;

  typedef struct {
    logic [7:0] data;
    outcome_e   outcome;
  } directed_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pfra_rx_if  rx_ch ();
  pfra_res_if res_ch ();
  pfra_cfg_if cfg_ch ();

  parameter_frame_receiver_with_ack_core #(
    .FrameBytes(FrameBytes)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_ch),
    .res_o (res_ch),
    .cfg_i (cfg_ch)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Receiver copy of the registers and of the frame being collected.
  logic [7:0]  hdr_reg  = pfra_pkg::RST_HEADER_BYTE;
  logic [7:0]  addr_reg = pfra_pkg::RST_DEVICE_ADDRESS;
  logic [7:0]  func_reg = pfra_pkg::RST_RETURN_FRAME_ID;
  logic [7:0]  code_reg = pfra_pkg::RST_WRITE_CODE;
  logic [7:0]  held_bytes [FrameBytes];
  int unsigned held_count = 0;

  result_t     due_results [$];
  logic [7:0]  rx_plan [$];
  int unsigned fail_count  = 0;
  int unsigned rx_accepted = 0;
  int unsigned rx_calm     = 0;
  int unsigned res_calm    = 0;
  int unsigned res_wait    = 0;
  logic        res_hold    = 1'b0;

  logic [pfra_pkg::CfgIdxW-1:0] reg_index [CfgRegs] = '{
    pfra_pkg::CFG_HEADER_BYTE, pfra_pkg::CFG_DEVICE_ADDRESS,
    pfra_pkg::CFG_RETURN_FRAME_ID, pfra_pkg::CFG_WRITE_CODE};
  logic [7:0] reg_reset [CfgRegs] = '{
    pfra_pkg::RST_HEADER_BYTE, pfra_pkg::RST_DEVICE_ADDRESS,
    pfra_pkg::RST_RETURN_FRAME_ID, pfra_pkg::RST_WRITE_CODE};

  // After reset: a stray byte, a good frame at the field extremes
  // (id 0xFFFF, value most negative, full length 6), then a frame whose length is 255.
  directed_row_t dir_rows [25] = '{
    '{8'h00, OUT_NONE},
    '{pfra_pkg::RST_HEADER_BYTE, OUT_NONE}, '{8'h01, OUT_NONE}, '{8'h02, OUT_NONE},
    '{8'h06, OUT_NONE}, '{8'hFF, OUT_NONE}, '{8'hFF, OUT_NONE},
    '{8'h00, OUT_NONE}, '{8'h00, OUT_NONE}, '{8'h00, OUT_NONE},
    '{8'h80, OUT_NONE}, '{8'h31, OUT_NONE}, '{8'h5C, OUT_PREDICT},
    '{pfra_pkg::RST_HEADER_BYTE, OUT_NONE}, '{8'h00, OUT_NONE}, '{8'h00, OUT_NONE},
    '{8'hFF, OUT_NONE}, '{8'h00, OUT_NONE}, '{8'hFF, OUT_NONE},
    '{8'h00, OUT_NONE}, '{8'hFF, OUT_NONE}, '{8'h00, OUT_NONE},
    '{8'hFF, OUT_NONE}, '{8'h00, OUT_NONE}, '{8'hFF, OUT_NONE}
  };

  // Idle cycles before the next transfer, with occasional stretches of none.
  function automatic int unsigned draw_gap(ref int unsigned calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, MaxGap);
  endfunction

  // Feed one received byte to the frame tracker and queue the results it causes.
  function automatic void absorb_rx_byte(input logic [7:0] b, input bit record);
    logic [7:0]  ack [AckBytes];
    logic [7:0]  s;
    logic [7:0]  a;
    int unsigned i;
    result_t     r;
    if (held_count >= FrameBytes) held_count = 0;
    held_bytes[held_count] = b;
    held_count++;
    // Hunting: anything not starting with the header restarts the count.
    if (held_bytes[0] != hdr_reg) begin
      held_count = 0;
      return;
    end
    if (held_count < FrameBytes) return;
    held_count = 0;
    if (held_bytes[pfra_pkg::LenPos] > MaxLen) return;
    s = '0;
    a = '0;
    for (i = 0; i < held_bytes[pfra_pkg::LenPos] + pfra_pkg::LenPos + 1; i++) begin
      s += held_bytes[i];
      a += s;
    end
    if (s != held_bytes[FrameBytes-2] || a != held_bytes[FrameBytes-1]) return;
    ack[pfra_pkg::ACK_POS_HEADER]  = hdr_reg;
    ack[pfra_pkg::ACK_POS_ADDRESS] = addr_reg;
    ack[pfra_pkg::ACK_POS_FUNC_ID] = func_reg;
    ack[pfra_pkg::ACK_POS_LENGTH]  = pfra_pkg::ACK_LENGTH;
    ack[pfra_pkg::ACK_POS_CODE]    = code_reg;
    ack[pfra_pkg::ACK_POS_RX_SUM]  = s;
    ack[pfra_pkg::ACK_POS_RX_ADD]  = a;
    s = '0;
    a = '0;
    for (i = 0; i < pfra_pkg::ACK_POS_OWN_SUM; i++) begin
      s += ack[i];
      a += s;
    end
    ack[pfra_pkg::ACK_POS_OWN_SUM] = s;
    ack[pfra_pkg::ACK_POS_OWN_ADD] = a;
    if (!record) return;
    for (i = 0; i < AckBytes; i++) begin
      r.kind = pfra_pkg::KIND_ACK;
      r.tx   = ack[i];
      r.id   = '0;
      r.val  = '0;
      r.last = 1'b0;
      due_results.push_back(r);
    end
    r.kind = pfra_pkg::KIND_PARAM;
    r.tx   = '0;
    r.id   = {held_bytes[pfra_pkg::IdHiPos], held_bytes[pfra_pkg::IdLoPos]};
    r.val  = {held_bytes[pfra_pkg::Val3Pos], held_bytes[pfra_pkg::Val2Pos],
              held_bytes[pfra_pkg::Val1Pos], held_bytes[pfra_pkg::Val0Pos]};
    r.last = 1'b1;
    due_results.push_back(r);
  endfunction

  // Compare one result transfer with the oldest expectation.
  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      fail_count++;
      if (fail_count <= MaxReports) begin
        $display("%0t: unexpected result kind=%0d tx=%02h id=%04h value=%08h last=%0d",
                 $time, res_ch.result_kind, res_ch.tx_byte, res_ch.param_id,
                 res_ch.param_value, res_ch.last);
      end
      return;
    end
    want = due_results.pop_front();
    if (res_ch.result_kind !== want.kind || res_ch.tx_byte !== want.tx ||
        res_ch.param_id !== want.id || res_ch.param_value !== want.val ||
        res_ch.last !== want.last) begin
      fail_count++;
      if (fail_count <= MaxReports) begin
        $display("%0t: expected kind=%0d tx=%02h id=%04h value=%08h last=%0d", $time,
                 want.kind, want.tx, want.id, want.val, want.last);
        $display("%0t:      got kind=%0d tx=%02h id=%04h value=%08h last=%0d", $time,
                 res_ch.result_kind, res_ch.tx_byte, res_ch.param_id,
                 res_ch.param_value, res_ch.last);
      end
    end
  endtask

  // Result side: check each transfer, then hold ready low for a drawn number of cycles.
  always @(posedge clk_i) begin
    if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      check_result();
      res_wait = draw_gap(res_calm);
    end
    if (res_hold || res_wait != 0) begin
      res_ch.ready <= 1'b0;
      if (!res_hold) res_wait--;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Long hold-off on the result side so the block backs up into its input.
  initial begin
    wait (rx_accepted >= HoldAfter);
    res_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    res_hold <= 1'b0;
  end

  // Offer every planned byte, one transfer at a time, with random gaps.
  task automatic send_plan();
    logic [7:0]  b;
    int unsigned gap;
    while (rx_plan.size() != 0) begin
      b   = rx_plan.pop_front();
      gap = draw_gap(rx_calm);
      if (gap != 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rx_ch.valid   <= 1'b1;
      rx_ch.rx_byte <= b;
      do @(posedge clk_i); while (rx_ch.ready !== 1'b1);
      rx_accepted++;
    end
    rx_ch.valid <= 1'b0;
  endtask

  // Wait for all results, then for any frame check that ends without output.
  task automatic settle();
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // Write all registers, optionally preceded by a write to an unused index.
  task automatic write_settings(input logic [7:0] vals [CfgRegs], input bit stray);
    logic [pfra_pkg::CfgIdxW-1:0] idx;
    logic [7:0]                   d;
    int unsigned                  w;
    for (w = 0; w <= CfgRegs; w++) begin
      if (w == 0) begin
        if (!stray) continue;
        idx = pfra_pkg::CfgIdxW'($urandom_range(int'(pfra_pkg::CFG_WRITE_CODE) + 1, 255));
        d   = 8'($urandom_range(0, 255));
      end else begin
        idx = reg_index[w-1];
        d   = vals[w-1];
      end
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= d;
      do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
      case (idx)
        pfra_pkg::CFG_HEADER_BYTE:     hdr_reg  = d;
        pfra_pkg::CFG_DEVICE_ADDRESS:  addr_reg = d;
        pfra_pkg::CFG_RETURN_FRAME_ID: func_reg = d;
        pfra_pkg::CFG_WRITE_CODE:      code_reg = d;
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [7:0]  fb [FrameBytes];
    logic [7:0]  vals [CfgRegs];
    logic [7:0]  s;
    logic [7:0]  a;
    logic [7:0]  b;
    int unsigned p;
    int unsigned r;
    int unsigned i;
    int unsigned n;
    int unsigned pick;
    int unsigned planned;

    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    res_ch.ready  = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table at the reset settings.
    foreach (dir_rows[k]) begin
      absorb_rx_byte(dir_rows[k].data, dir_rows[k].outcome == OUT_PREDICT);
      rx_plan.push_back(dir_rows[k].data);
    end
    send_plan();

    // Random phases: all zero, all ones, two random settings, back to reset values.
    for (p = 0; p < PhaseCount; p++) begin
      settle();
      for (r = 0; r < CfgRegs; r++) begin
        case (p)
          0:            vals[r] = 8'h00;
          1:            vals[r] = 8'hFF;
          PhaseCount-1: vals[r] = reg_reset[r];
          default:      vals[r] = 8'($urandom_range(0, 255));
        endcase
      end
      write_settings(vals, p == PhaseCount - 1);

      planned = 0;
      while (planned < PhaseBytes) begin
        pick = $urandom_range(0, 99);
        if (pick < 9) begin
          // Line noise that never looks like a header.
          n = $urandom_range(1, 3);
          for (i = 0; i < n; i++) begin
            do b = 8'($urandom_range(0, 255)); while (b == hdr_reg);
            absorb_rx_byte(b, 1'b1);
            rx_plan.push_back(b);
          end
          planned += n;
        end else begin
          fb[0] = hdr_reg;
          for (i = 1; i < FrameBytes; i++) fb[i] = 8'($urandom_range(0, 255));
          if (pick < 17) begin
            // Length beyond the frame; check bytes stay random.
            fb[pfra_pkg::LenPos] = 8'($urandom_range(MaxLen + 1, 255));
          end else begin
            fb[pfra_pkg::LenPos] = 8'($urandom_range(0, MaxLen));
            s = '0;
            a = '0;
            for (i = 0; i < fb[pfra_pkg::LenPos] + pfra_pkg::LenPos + 1; i++) begin
              s += fb[i];
              a += s;
            end
            // A few frames carry a corrupted running sum or sum of sums.
            if (pick < 22) s ^= 8'($urandom_range(1, 255));
            else if (pick < 27) a ^= 8'($urandom_range(1, 255));
            fb[FrameBytes-2] = s;
            fb[FrameBytes-1] = a;
          end
          // Some frames are cut short and run into whatever follows.
          n = (pick >= 27 && pick < 35) ? $urandom_range(1, FrameBytes - 1) : FrameBytes;
          for (i = 0; i < n; i++) begin
            absorb_rx_byte(fb[i], 1'b1);
            rx_plan.push_back(fb[i]);
          end
          planned += n;
        end
      end
      send_plan();
    end

    settle();
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
